// File: rtl/scspa_pkg.sv
// Package: shared types, codes and defaults for the sprite pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package scspa_pkg;

    localparam int NUM_CLASSES      = 4;
    localparam int LIMIT_W          = 18;
    localparam int CFG_INDEX_W      = 2;

    localparam int DEF_SLOT_COUNT     = 32;
    localparam int DEF_CLASS0_BUCKETS = 8;
    localparam int DEF_CLASS1_BUCKETS = 8;
    localparam int DEF_CLASS2_BUCKETS = 8;
    localparam int DEF_CLASS3_BUCKETS = 8;

    localparam logic [LIMIT_W-1:0] CLASS0_LIMIT_RST = 18'd48;
    localparam logic [LIMIT_W-1:0] CLASS1_LIMIT_RST = 18'd160;
    localparam logic [LIMIT_W-1:0] CLASS2_LIMIT_RST = 18'd576;
    localparam logic [LIMIT_W-1:0] CLASS3_LIMIT_RST = 18'd2176;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LOCATE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SLOT    = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ST_CLASS_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         sprite_width;
        logic [9:0]         sprite_height;
        logic [5:0]         handle;
        logic signed [15:0] x_position;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot_handle;
        logic [1:0]  size_class;
        logic [2:0]  bucket_index;
        logic [2:0]  pixel_shift;
        logic [7:0]  row_pitch;
        logic [17:0] byte_size;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/scspa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module scspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/size_class_sprite_pool_allocator.sv
// Top level: size-class sprite pool allocator with a sequential map scanner.
// Allocate: S_MUL forms pitch and size; S_SLOT finds the lowest free slot, S_CLASS the first
//   fitting class, S_BUCKET the lowest free bucket; one comparator and counter per scan.
// Free and locate: S_HCHK checks the handle, S_HDATA uses the registered read of the slot table RAM.
// Clear: S_CLR empties all maps. One item at a time; done pulses one cycle, receiver cannot stall.
// Reset (rst_n, async low) empties all maps and loads the default class limits.
`timescale 1ns / 1ps
`default_nettype none
module size_class_sprite_pool_allocator #(
    parameter int SLOT_COUNT     = scspa_pkg::DEF_SLOT_COUNT,
    parameter int CLASS0_BUCKETS = scspa_pkg::DEF_CLASS0_BUCKETS,
    parameter int CLASS1_BUCKETS = scspa_pkg::DEF_CLASS1_BUCKETS,
    parameter int CLASS2_BUCKETS = scspa_pkg::DEF_CLASS2_BUCKETS,
    parameter int CLASS3_BUCKETS = scspa_pkg::DEF_CLASS3_BUCKETS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire scspa_pkg::cmd_t                    cmd,
    output logic                                    done,
    output scspa_pkg::result_t                      result,
    input  wire logic                               cfg_we,
    input  wire logic [scspa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [scspa_pkg::LIMIT_W-1:0]      cfg_data
);

    import scspa_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int M01 = (CLASS0_BUCKETS > CLASS1_BUCKETS) ? CLASS0_BUCKETS : CLASS1_BUCKETS;
    localparam int M23 = (CLASS2_BUCKETS > CLASS3_BUCKETS) ? CLASS2_BUCKETS : CLASS3_BUCKETS;
    localparam int MAXB = (M01 > M23) ? M01 : M23;
    localparam int BW = (MAXB > 1) ? $clog2(MAXB) : 1;
    localparam int RW = 2 + BW;

    localparam logic [BW-1:0] B0_LAST = BW'(CLASS0_BUCKETS - 1);
    localparam logic [BW-1:0] B1_LAST = BW'(CLASS1_BUCKETS - 1);
    localparam logic [BW-1:0] B2_LAST = BW'(CLASS2_BUCKETS - 1);
    localparam logic [BW-1:0] B3_LAST = BW'(CLASS3_BUCKETS - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);
    localparam logic [6:0]    SLOT_LIM  = 7'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SLOT, S_CLASS, S_BUCKET, S_HCHK, S_HDATA, S_CLR
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [7:0]           pitch_reg;
    logic [LIMIT_W-1:0]   size_reg;
    logic [SW-1:0]        slot_cnt_reg, slot_cnt_next;
    logic [1:0]           class_cnt_reg, class_cnt_next;
    logic [BW-1:0]        bkt_cnt_reg, bkt_cnt_next;
    logic [SLOT_COUNT-1:0] slot_in_use_reg;
    logic [MAXB-1:0]      busy_map_reg [NUM_CLASSES];
    logic [LIMIT_W-1:0]   limit_reg [NUM_CLASSES];
    logic                 done_reg;
    result_t              result_reg, res_next;
    logic                 finish, alloc_commit, free_commit, clear_commit;

    logic [10:0]          wsum;
    logic [7:0]           pitch_comb;
    logic [SW-1:0]        hidx;
    logic                 handle_ok;
    logic [BW-1:0]        bkt_last;
    logic [RW-1:0]        ram_rdata;
    logic [1:0]           rd_class;
    logic [BW-1:0]        rd_bkt;
    logic [SW+4:0]        slot_ext;
    logic [BW+2:0]        bkt_ext, rd_bkt_ext;

    assign wsum       = {1'b0, cmd_reg.sprite_width} + 11'd7;
    assign pitch_comb = wsum[10:3] + 8'd1;
    assign hidx       = cmd_reg.handle[SW-1:0];
    assign handle_ok  = ({1'b0, cmd_reg.handle} < SLOT_LIM) && slot_in_use_reg[hidx];
    assign rd_class   = ram_rdata[RW-1:BW];
    assign rd_bkt     = ram_rdata[BW-1:0];
    assign slot_ext   = (SW+5)'(slot_cnt_reg);
    assign bkt_ext    = (BW+3)'(bkt_cnt_reg);
    assign rd_bkt_ext = (BW+3)'(rd_bkt);

    always_comb
    begin
        case (class_cnt_reg)
            2'd0:    bkt_last = B0_LAST;
            2'd1:    bkt_last = B1_LAST;
            2'd2:    bkt_last = B2_LAST;
            default: bkt_last = B3_LAST;
        endcase
    end

    scspa_ram #(
        .WIDTH (RW),
        .DEPTH (SLOT_COUNT),
        .AW    (SW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (alloc_commit),
        .waddr (slot_cnt_reg),
        .wdata ({class_cnt_reg, bkt_cnt_reg}),
        .raddr (hidx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        slot_cnt_next  = slot_cnt_reg;
        class_cnt_next = class_cnt_reg;
        bkt_cnt_next   = bkt_cnt_reg;
        finish         = 1'b0;
        alloc_commit   = 1'b0;
        free_commit    = 1'b0;
        clear_commit   = 1'b0;
        res_next           = '0;
        res_next.row_pitch = pitch_reg;
        res_next.byte_size = size_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.opcode)
                        OP_ALLOC: state_next = S_MUL;
                        OP_CLEAR: state_next = S_CLR;
                        default:  state_next = S_HCHK;
                    endcase
                end
            end
            S_MUL:
            begin
                slot_cnt_next = '0;
                state_next    = S_SLOT;
            end
            S_SLOT:
            begin
                if (!slot_in_use_reg[slot_cnt_reg])
                begin
                    class_cnt_next = '0;
                    state_next     = S_CLASS;
                end
                else if (slot_cnt_reg == SLOT_LAST)
                begin
                    res_next.status = ST_NO_SLOT;
                    finish          = 1'b1;
                end
                else
                begin
                    slot_cnt_next = slot_cnt_reg + 1'b1;
                end
            end
            S_CLASS:
            begin
                if (size_reg <= limit_reg[class_cnt_reg])
                begin
                    bkt_cnt_next = '0;
                    state_next   = S_BUCKET;
                end
                else if (class_cnt_reg == 2'd3)
                begin
                    res_next.status = ST_TOO_LARGE;
                    finish          = 1'b1;
                end
                else
                begin
                    class_cnt_next = class_cnt_reg + 2'd1;
                end
            end
            S_BUCKET:
            begin
                if (!busy_map_reg[class_cnt_reg][bkt_cnt_reg])
                begin
                    alloc_commit          = 1'b1;
                    res_next.status       = ST_OK;
                    res_next.slot_handle  = slot_ext[4:0];
                    res_next.size_class   = class_cnt_reg;
                    res_next.bucket_index = bkt_ext[2:0];
                    finish                = 1'b1;
                end
                else if (bkt_cnt_reg == bkt_last)
                begin
                    res_next.status     = ST_CLASS_FULL;
                    res_next.size_class = class_cnt_reg;
                    finish              = 1'b1;
                end
                else
                begin
                    bkt_cnt_next = bkt_cnt_reg + 1'b1;
                end
            end
            S_HCHK:
            begin
                if (handle_ok)
                begin
                    state_next = S_HDATA;
                end
                else
                begin
                    res_next             = '0;
                    res_next.status      = ST_BAD_HANDLE;
                    res_next.slot_handle = cmd_reg.handle[4:0];
                    finish               = 1'b1;
                end
            end
            S_HDATA:
            begin
                res_next              = '0;
                res_next.status       = ST_OK;
                res_next.slot_handle  = cmd_reg.handle[4:0];
                res_next.size_class   = rd_class;
                res_next.bucket_index = rd_bkt_ext[2:0];
                if (cmd_reg.opcode == OP_FREE)
                begin
                    free_commit = 1'b1;
                end
                else
                begin
                    res_next.pixel_shift = cmd_reg.x_position[2:0];
                end
                finish = 1'b1;
            end
            S_CLR:
            begin
                res_next     = '0;
                clear_commit = 1'b1;
                finish       = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (finish)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            slot_cnt_reg    <= '0;
            class_cnt_reg   <= '0;
            bkt_cnt_reg     <= '0;
            slot_in_use_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                busy_map_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= finish;
            slot_cnt_reg  <= slot_cnt_next;
            class_cnt_reg <= class_cnt_next;
            bkt_cnt_reg   <= bkt_cnt_next;
            if (alloc_commit)
            begin
                slot_in_use_reg[slot_cnt_reg]               <= 1'b1;
                busy_map_reg[class_cnt_reg][bkt_cnt_reg]    <= 1'b1;
            end
            if (free_commit)
            begin
                slot_in_use_reg[hidx]          <= 1'b0;
                busy_map_reg[rd_class][rd_bkt] <= 1'b0;
            end
            if (clear_commit)
            begin
                slot_in_use_reg <= '0;
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    busy_map_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_MUL)
        begin
            pitch_reg <= pitch_comb;
            size_reg  <= LIMIT_W'(pitch_comb) * LIMIT_W'(cmd_reg.sprite_height);
        end
        if (finish)
        begin
            result_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg[0] <= CLASS0_LIMIT_RST;
            limit_reg[1] <= CLASS1_LIMIT_RST;
            limit_reg[2] <= CLASS2_LIMIT_RST;
            limit_reg[3] <= CLASS3_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            limit_reg[cfg_index] <= cfg_data;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// File: rtl/scspa_checker.sv
// Checker: port-level assertions for the sprite pool allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module scspa_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire scspa_pkg::result_t result
);

    import scspa_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result transfer without a command in progress");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.pixel_shift == 3'd0 && result.bucket_index == 3'd0))
        else $error("error result carries bucket or shift");

endmodule

bind size_class_sprite_pool_allocator scspa_checker u_scspa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

// File: tb/sv/size_class_sprite_pool_allocator_tb.sv
// Self-checking testbench for the size-class sprite pool allocator.
`timescale 1ns / 1ps
module size_class_sprite_pool_allocator_tb;
    import scspa_pkg::*;

    localparam int SLOT_COUNT = DEF_SLOT_COUNT;
    localparam int BUCKETS [NUM_CLASSES] = '{DEF_CLASS0_BUCKETS, DEF_CLASS1_BUCKETS,
                                             DEF_CLASS2_BUCKETS, DEF_CLASS3_BUCKETS};
    localparam int PHASE_ITEMS = 275;
    localparam int QUIET_LIMIT = 3000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    cmd_t                   cmd = '0;
    logic                   done;
    result_t                result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]     cfg_data = '0;

    cmd_t    cmd_backlog[$];
    result_t predicted_results[$];
    int      mismatch_count = 0;
    int      idle_pct = 0;
    bit      drain_wait = 1'b0;
    int      quiet_cycles = 0;

    // allocator shadow state
    logic [LIMIT_W-1:0] class_limit [NUM_CLASSES];
    bit                 slot_used [SLOT_COUNT];
    logic [1:0]         slot_cls [SLOT_COUNT];
    logic [2:0]         slot_bkt [SLOT_COUNT];
    logic [7:0]         bucket_map [NUM_CLASSES];

    size_class_sprite_pool_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void empty_pool();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_used[i] = 1'b0;
            slot_cls[i]  = '0;
            slot_bkt[i]  = '0;
        end
        for (int k = 0; k < NUM_CLASSES; k++)
            bucket_map[k] = '0;
    endfunction

    function automatic result_t allocator_step(input cmd_t c);
        result_t r;
        int      pitch;
        int      size;
        int      slot;
        int      cls;
        int      b;
        r = '0;
        case (c.opcode)
            OP_ALLOC:
            begin
                pitch = (int'(c.sprite_width) + 7) / 8 + 1;
                size = pitch * int'(c.sprite_height);
                r.row_pitch = pitch[7:0];
                r.byte_size = size[17:0];
                slot = -1;
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (!slot_used[i])
                        slot = i;
                if (slot < 0)
                    r.status = ST_NO_SLOT;
                else
                begin
                    cls = -1;
                    for (int k = NUM_CLASSES - 1; k >= 0; k--)
                        if (size <= int'(class_limit[k]))
                            cls = k;
                    if (cls < 0)
                        r.status = ST_TOO_LARGE;
                    else
                    begin
                        b = -1;
                        for (int k = BUCKETS[cls] - 1; k >= 0; k--)
                            if (!bucket_map[cls][k])
                                b = k;
                        r.size_class = cls[1:0];
                        if (b < 0)
                            r.status = ST_CLASS_FULL;
                        else
                        begin
                            bucket_map[cls][b] = 1'b1;
                            slot_used[slot] = 1'b1;
                            slot_cls[slot] = cls[1:0];
                            slot_bkt[slot] = b[2:0];
                            r.status = ST_OK;
                            r.slot_handle = slot[4:0];
                            r.bucket_index = b[2:0];
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                empty_pool();
                r.status = ST_OK;
            end
            default:
            begin
                r.slot_handle = c.handle[4:0];
                if (int'(c.handle) >= SLOT_COUNT || !slot_used[c.handle])
                    r.status = ST_BAD_HANDLE;
                else
                begin
                    r.status = ST_OK;
                    r.size_class = slot_cls[c.handle];
                    r.bucket_index = slot_bkt[c.handle];
                    if (c.opcode == OP_FREE)
                    begin
                        bucket_map[slot_cls[c.handle]][slot_bkt[c.handle]] = 1'b0;
                        slot_used[c.handle] = 1'b0;
                        slot_cls[c.handle] = '0;
                        slot_bkt[c.handle] = '0;
                    end
                    else
                        r.pixel_shift = c.x_position[2:0];
                end
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic [1:0] op, input int w, input int h,
                                      input int hd, input int x);
        cmd_t c;
        c.opcode        = op;
        c.sprite_width  = w[9:0];
        c.sprite_height = h[9:0];
        c.handle        = hd[5:0];
        c.x_position    = x[15:0];
        return c;
    endfunction

    // every class can be filled with pitch-1 sprites when the limits are ordered
    function automatic bit fill_possible();
        bit ok;
        ok = 1'b1;
        for (int k = 1; k < NUM_CLASSES; k++)
            if (int'(class_limit[k-1]) + 1 > ((class_limit[k] > 1023) ? 1023 : int'(class_limit[k])))
                ok = 1'b0;
        return ok;
    endfunction

    task automatic queue_fill_sequence(inout int n);
        int left [NUM_CLASSES];
        int c;
        int lo;
        int hi;
        for (int k = 0; k < NUM_CLASSES; k++)
            left[k] = BUCKETS[k];
        cmd_backlog.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0));
        n++;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            do
                c = $urandom_range(0, NUM_CLASSES - 1);
            while (left[c] == 0);
            left[c]--;
            lo = (c == 0) ? 0 : int'(class_limit[c-1]) + 1;
            hi = (class_limit[c] > 1023) ? 1023 : int'(class_limit[c]);
            cmd_backlog.push_back(make_cmd(OP_ALLOC, 0, $urandom_range(lo, hi),
                                           $urandom_range(0, 63), $urandom));
            n++;
        end
        repeat ($urandom_range(1, 3))
        begin
            cmd_backlog.push_back(make_cmd(OP_ALLOC, $urandom_range(0, 1023),
                                           $urandom_range(0, 1023), 0, 0));
            n++;
        end
        repeat ($urandom_range(2, 6))
        begin
            cmd_backlog.push_back(make_cmd($urandom_range(0, 1) ? OP_FREE : OP_LOCATE, 0, 0,
                                           $urandom_range(0, 31), $urandom));
            n++;
        end
    endtask

    task automatic queue_random_phase(input int count);
        int n;
        int r;
        int w;
        int h;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 4 && fill_possible())
                queue_fill_sequence(n);
            else
            begin
                if (r < 14)
                    cmd_backlog.push_back(make_cmd(2'($urandom_range(0, 2)),
                                                   $urandom_range(0, 1023),
                                                   $urandom_range(0, 1023),
                                                   $urandom_range(0, 63), $urandom));
                else if (r < 16)
                    cmd_backlog.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0));
                else if (r < 64)
                begin
                    if ($urandom_range(0, 99) < 70)
                    begin
                        w = $urandom_range(0, 80);
                        h = $urandom_range(0, 40);
                    end
                    else
                    begin
                        w = $urandom_range(0, 1023);
                        h = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 30)
                                                         : $urandom_range(0, 1023);
                    end
                    cmd_backlog.push_back(make_cmd(OP_ALLOC, w, h, 0, 0));
                end
                else
                    cmd_backlog.push_back(make_cmd((r < 86) ? OP_FREE : OP_LOCATE, 0, 0,
                                                   $urandom_range(0, $urandom_range(0, 31)),
                                                   $urandom));
                n++;
            end
        end
    endtask

    task automatic queue_directed();
        cmd_backlog.push_back(make_cmd(OP_LOCATE, 0, 0, 0, 5));
        cmd_backlog.push_back(make_cmd(OP_FREE, 0, 0, 63, 0));
        cmd_backlog.push_back(make_cmd(OP_LOCATE, 0, 0, 32, 0));
        cmd_backlog.push_back(make_cmd(OP_ALLOC, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_ALLOC, 1023, 1023, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_ALLOC, 8, 24, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_ALLOC, 8, 25, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_ALLOC, 1023, 16, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_ALLOC, 1016, 4, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_LOCATE, 0, 0, 3, -1));
        cmd_backlog.push_back(make_cmd(OP_LOCATE, 0, 0, 3, -32768));
        cmd_backlog.push_back(make_cmd(OP_LOCATE, 0, 0, 4, 32767));
        cmd_backlog.push_back(make_cmd(OP_FREE, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(OP_FREE, 0, 0, 1, 0));
        // fill class 0, last one finds it full
        repeat (8)
            cmd_backlog.push_back(make_cmd(OP_ALLOC, 0, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_CLEAR, 1023, 1023, 63, -1));
        cmd_backlog.push_back(make_cmd(OP_LOCATE, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_ALLOC, 1, 1, 0, 0));
    endtask

    // sampled at the falling edge so that a start driven at the last rising edge is seen
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || start || busy || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input int idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_INDEX_W-1:0];
        cfg_data  <= value[LIMIT_W-1:0];
        class_limit[idx] = value[LIMIT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [17:0] want,
                               input logic [17:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted_results.push_back(allocator_step(cmd));
                if ($urandom_range(0, 149) == 0)
                    drain_wait = 1'b1;
            end
            if (drain_wait && predicted_results.size() == 0)
                drain_wait = 1'b0;
            if (!(start && busy))
            begin
                if (cmd_backlog.size() != 0 && !drain_wait && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    cmd   <= cmd_backlog.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result transfer, expected none actual %p", $time, result);
            end
            else
            begin
                result_t want;
                want = predicted_results.pop_front();
                check_field("status", 18'(want.status), 18'(result.status));
                check_field("slot_handle", 18'(want.slot_handle), 18'(result.slot_handle));
                check_field("size_class", 18'(want.size_class), 18'(result.size_class));
                check_field("bucket_index", 18'(want.bucket_index), 18'(result.bucket_index));
                check_field("pixel_shift", 18'(want.pixel_shift), 18'(result.pixel_shift));
                check_field("row_pitch", 18'(want.row_pitch), 18'(result.row_pitch));
                check_field("byte_size", want.byte_size, result.byte_size);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("size_class_sprite_pool_allocator regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int limits [6][NUM_CLASSES];
        int idles [6];
        limits = '{'{48, 160, 576, 2176}, '{0, 10, 100, 1000},
                   '{262143, 262143, 262143, 262143}, '{500, 20, 262143, 0},
                   '{0, 0, 0, 0}, '{30, 90, 400, 1000}};
        idles = '{31, 31, 46, 46, 0, 0};
        class_limit[0] = CLASS0_LIMIT_RST;
        class_limit[1] = CLASS1_LIMIT_RST;
        class_limit[2] = CLASS2_LIMIT_RST;
        class_limit[3] = CLASS3_LIMIT_RST;
        empty_pool();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            repeat (4) @(posedge clk);
            if (p != 0)
                for (int k = 0; k < NUM_CLASSES; k++)
                    write_limit(k, limits[p][k]);
            idle_pct = idles[p];
            if (p == 0)
                queue_directed();
            queue_random_phase(PHASE_ITEMS);
        end
        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("size_class_sprite_pool_allocator regression: pass");
        else
            $display("size_class_sprite_pool_allocator regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/scspa_pkg.sv
rtl/scspa_ram.sv
rtl/size_class_sprite_pool_allocator.sv
rtl/scspa_checker.sv
tb/sv/size_class_sprite_pool_allocator_tb.sv
